>>> rtl/ppwc_pkg.sv
// Shared constants, slot record types and status codes for the page window cache.
package ppwc_pkg;

  localparam int SLOT_COUNT   = 1024;
  // Bucket count must be a power of two: the bucket index is the low frame bits.
  localparam int BUCKET_COUNT = 256;
  localparam int PAGE_SHIFT   = 12;
  localparam int REF_BITS     = 16;
  localparam int FRAME_BITS   = 20;

  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int LINK_BITS = SLOT_BITS + 1;
  localparam int BKT_BITS  = $clog2(BUCKET_COUNT);

  typedef logic [LINK_BITS-1:0] link_t;

  localparam link_t NO_SLOT   = LINK_BITS'(SLOT_COUNT);
  localparam link_t LAST_SLOT = LINK_BITS'(SLOT_COUNT - 1);
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  // One slot record: bound frame, reference count, hash chain link, LRU links.
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic [REF_BITS-1:0]   refs;
    link_t                 chain;
    link_t                 after;
    link_t                 prior;
  } slot_rec_t;

  // Per-field write enables for a slot record.
  typedef struct packed {
    logic frame;
    logic refs;
    logic chain;
    logic after;
    logic prior;
  } rec_mask_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_BAD_UNLOCK = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

endpackage

>>> rtl/ppwc_slot_ram.sv
// Slot record memory with one registered read port and a field-masked write port.
module ppwc_slot_ram (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ppwc_pkg::SLOT_BITS-1:0] rd_addr,
  output ppwc_pkg::slot_rec_t           rd_data,
  input  logic                          wr_en,
  input  logic [ppwc_pkg::SLOT_BITS-1:0] wr_addr,
  input  ppwc_pkg::rec_mask_t           wr_mask,
  input  ppwc_pkg::slot_rec_t           wr_data
);
  import ppwc_pkg::*;

  slot_rec_t mem [SLOT_COUNT];

  // Each field is written only when its enable is set.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_mask.frame) mem[wr_addr].frame <= wr_data.frame;
      if (wr_mask.refs)  mem[wr_addr].refs  <= wr_data.refs;
      if (wr_mask.chain) mem[wr_addr].chain <= wr_data.chain;
      if (wr_mask.after) mem[wr_addr].after <= wr_data.after;
      if (wr_mask.prior) mem[wr_addr].prior <= wr_data.prior;
    end
  end

  // Read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/physical_page_window_cache.sv
// Top level of the physical page window cache: sequencer, bucket table and output register.
// An unlock reads its slot record unless the slot number is out of range; a lock reads the
// bucket and walks the chain of the new page; a miss into a reused slot also walks the former
// chain of the victim to unlink it, then binds the page at the front of its new chain.
// One word is handled at a time; the next is accepted in the cycle after the result is loaded.
// Reset: synchronous; slots from 1 up free in order, buckets empty, counters zero, no clearing pass.
module physical_page_window_cache (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [19:0]  cfg_data,       // window_base_page
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // phys_page[19:0], slot_in[29:20], zero fill
  input  logic         s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata    // slot_out, virtual_address, hit, pte_write,
                                       // pte_value, status, hit_total, request_total
);
  import ppwc_pkg::*;

  typedef enum logic [14:0] {
    IDLE   = 15'b000000000000001,
    L_BKT  = 15'b000000000000010,
    L_WALK = 15'b000000000000100,
    M_RD   = 15'b000000000001000,
    M_LRU  = 15'b000000000010000,
    R_BKT  = 15'b000000000100000,
    R_WALK = 15'b000000001000000,
    R_WR   = 15'b000000010000000,
    I_REQ  = 15'b000000100000000,
    I_BKT  = 15'b000001000000000,
    H_B    = 15'b000010000000000,
    H_A    = 15'b000100000000000,
    U_RD   = 15'b001000000000000,
    U_T    = 15'b010000000000000,
    FIN    = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  logic [FRAME_BITS-1:0] base;
  logic [FRAME_BITS-1:0] page;
  logic [FRAME_BITS-1:0] old_frame;
  link_t s, cur, prev, a, b, link_s;
  link_t fill, head, tail, last_after;
  logic bound_f, hit_f, pw_f, va_en;
  status_t status;
  logic [31:0] hit_cnt, req_cnt;

  // Slot memory ports.
  logic                 rd_en, wr_en;
  logic [SLOT_BITS-1:0] rd_addr, wr_addr;
  slot_rec_t            rd_data, wr_data;
  rec_mask_t            wr_mask;

  // Bucket table: heads of the hash chains, with valid bits cleared by reset.
  link_t                bkt_mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] bkt_valid;
  link_t                bkt_q;
  logic                 bkt_rd_en, bkt_wr_en;
  logic [BKT_BITS-1:0]  bkt_rd_addr, bkt_wr_addr;
  link_t                bkt_wr_data;

  logic s_accept, out_free, miss_go, match, h_bound;
  link_t head_after;
  logic [9:0] in_sin;

  assign s_axis_tready = (state == IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign in_sin        = s_axis_tdata[29:20];
  assign match         = (rd_data.frame == page);

  // Slots at or above the fill mark were never bound and keep their reset LRU links.
  assign h_bound    = (head < fill);
  assign head_after = (head == LAST_SLOT) ? last_after : link_t'(head + 1'b1);

  ppwc_slot_ram u_slot_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_mask (wr_mask),
    .wr_data (wr_data)
  );

  // Bucket table read and write.
  always_ff @(posedge clk) begin
    if (bkt_rd_en) begin
      bkt_q <= bkt_valid[bkt_rd_addr] ? bkt_mem[bkt_rd_addr] : NO_SLOT;
    end
    if (bkt_wr_en) begin
      bkt_mem[bkt_wr_addr] <= bkt_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bkt_valid <= '0;
    end else if (bkt_wr_en) begin
      bkt_valid[bkt_wr_addr] <= 1'b1;
    end
  end

  // Sequencer: memory port control and next state.
  always_comb begin
    state_next  = state;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_mask     = '0;
    wr_data     = '0;
    bkt_rd_en   = 1'b0;
    bkt_rd_addr = '0;
    bkt_wr_en   = 1'b0;
    bkt_wr_addr = '0;
    bkt_wr_data = '0;
    miss_go     = 1'b0;
    case (state)
      IDLE: begin
        if (s_accept) begin
          if (!s_axis_tuser) begin
            bkt_rd_en   = 1'b1;
            bkt_rd_addr = s_axis_tdata[BKT_BITS-1:0];
            state_next  = L_BKT;
          end else if (in_sin == 10'd0 || {1'b0, in_sin} >= fill) begin
            state_next = FIN;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = in_sin[SLOT_BITS-1:0];
            state_next = U_RD;
          end
        end
      end
      L_BKT: begin
        if (bkt_q == NO_SLOT) begin
          miss_go = 1'b1;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = bkt_q[SLOT_BITS-1:0];
          state_next = L_WALK;
        end
      end
      L_WALK: begin
        if (match) begin
          if (rd_data.refs == REF_MAX) begin
            state_next = FIN;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = cur[SLOT_BITS-1:0];
            wr_mask.refs = 1'b1;
            wr_data.refs = REF_BITS'(rd_data.refs + 1'b1);
            if (rd_data.refs == '0) begin
              wr_mask.after = 1'b1;
              wr_mask.prior = 1'b1;
              wr_data.after = NO_SLOT;
              wr_data.prior = NO_SLOT;
              state_next    = H_B;
            end else begin
              state_next = FIN;
            end
          end
        end else if (rd_data.chain == NO_SLOT) begin
          miss_go = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_data.chain[SLOT_BITS-1:0];
        end
      end
      M_RD: begin
        state_next = M_LRU;
      end
      M_LRU: begin
        // The victim is the list head, so only its successor needs a new back link.
        if (a != NO_SLOT) begin
          wr_en         = 1'b1;
          wr_addr       = a[SLOT_BITS-1:0];
          wr_mask.prior = 1'b1;
          wr_data.prior = NO_SLOT;
        end
        bkt_rd_en   = 1'b1;
        bkt_rd_addr = bound_f ? old_frame[BKT_BITS-1:0] : page[BKT_BITS-1:0];
        state_next  = bound_f ? R_BKT : I_BKT;
      end
      R_BKT: begin
        if (bkt_q == s) begin
          state_next = R_WR;
        end else if (bkt_q == NO_SLOT) begin
          state_next = I_REQ;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = bkt_q[SLOT_BITS-1:0];
          state_next = R_WALK;
        end
      end
      R_WALK: begin
        if (rd_data.chain == s) begin
          state_next = R_WR;
        end else if (rd_data.chain == NO_SLOT) begin
          state_next = I_REQ;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_data.chain[SLOT_BITS-1:0];
        end
      end
      R_WR: begin
        // Unlink the victim from the chain of its former page.
        if (prev == NO_SLOT) begin
          bkt_wr_en   = 1'b1;
          bkt_wr_addr = old_frame[BKT_BITS-1:0];
          bkt_wr_data = link_s;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = prev[SLOT_BITS-1:0];
          wr_mask.chain = 1'b1;
          wr_data.chain = link_s;
        end
        state_next = I_REQ;
      end
      I_REQ: begin
        bkt_rd_en   = 1'b1;
        bkt_rd_addr = page[BKT_BITS-1:0];
        state_next  = I_BKT;
      end
      I_BKT: begin
        // Bind the new page and put the slot at the front of its chain.
        wr_en         = 1'b1;
        wr_addr       = s[SLOT_BITS-1:0];
        wr_mask       = '1;
        wr_data.frame = page;
        wr_data.refs  = REF_BITS'(1);
        wr_data.chain = bkt_q;
        wr_data.after = NO_SLOT;
        wr_data.prior = NO_SLOT;
        bkt_wr_en     = 1'b1;
        bkt_wr_addr   = page[BKT_BITS-1:0];
        bkt_wr_data   = s;
        state_next    = FIN;
      end
      H_B: begin
        if (b != NO_SLOT) begin
          wr_en         = 1'b1;
          wr_addr       = b[SLOT_BITS-1:0];
          wr_mask.after = 1'b1;
          wr_data.after = a;
        end
        state_next = H_A;
      end
      H_A: begin
        if (a != NO_SLOT) begin
          wr_en         = 1'b1;
          wr_addr       = a[SLOT_BITS-1:0];
          wr_mask.prior = 1'b1;
          wr_data.prior = b;
        end
        state_next = FIN;
      end
      U_RD: begin
        if (rd_data.refs == '0) begin
          state_next = FIN;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = s[SLOT_BITS-1:0];
          wr_mask.refs = 1'b1;
          wr_data.refs = REF_BITS'(rd_data.refs - 1'b1);
          if (rd_data.refs == REF_BITS'(1)) begin
            wr_mask.after = 1'b1;
            wr_mask.prior = 1'b1;
            wr_data.after = NO_SLOT;
            wr_data.prior = tail;
            state_next    = U_T;
          end else begin
            state_next = FIN;
          end
        end
      end
      U_T: begin
        if (tail != NO_SLOT) begin
          wr_en         = 1'b1;
          wr_addr       = tail[SLOT_BITS-1:0];
          wr_mask.after = 1'b1;
          wr_data.after = s;
        end
        state_next = FIN;
      end
      FIN: begin
        if (out_free) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase

    // A miss takes the oldest free slot; a bound one needs its record first.
    if (miss_go) begin
      if (head == NO_SLOT) begin
        state_next = FIN;
      end else if (h_bound) begin
        rd_en      = 1'b1;
        rd_addr    = head[SLOT_BITS-1:0];
        state_next = M_RD;
      end else begin
        state_next = M_LRU;
      end
    end
  end

  // Control state: sequencer, list ends, fill mark, counters and base register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      fill          <= link_t'(1);
      head          <= (SLOT_COUNT > 1) ? link_t'(1) : NO_SLOT;
      tail          <= LAST_SLOT;
      last_after    <= NO_SLOT;
      hit_cnt       <= '0;
      req_cnt       <= '0;
      base          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        base <= cfg_data;
      end
      if (s_accept && !s_axis_tuser) begin
        req_cnt <= req_cnt + 32'd1;
      end
      if (state == L_WALK && match) begin
        hit_cnt <= hit_cnt + 32'd1;
      end
      if (state == M_LRU) begin
        head <= a;
        if (a == NO_SLOT) begin
          tail <= NO_SLOT;
        end
      end
      if (state == I_BKT && s == fill) begin
        fill <= link_t'(fill + 1'b1);
      end
      if (state == H_B) begin
        if (b == NO_SLOT) begin
          head <= a;
        end else if (b == LAST_SLOT && b >= fill) begin
          last_after <= a;
        end
      end
      if (state == H_A && a == NO_SLOT) begin
        tail <= b;
      end
      if (state == U_T) begin
        if (tail == NO_SLOT) begin
          head <= s;
        end else if (tail == LAST_SLOT && tail >= fill) begin
          last_after <= s;
        end
        tail <= s;
      end
      if (state == FIN && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Working registers of the word in progress.
  always_ff @(posedge clk) begin
    case (state)
      IDLE: begin
        if (s_accept) begin
          page    <= s_axis_tdata[FRAME_BITS-1:0];
          s       <= {1'b0, in_sin};
          hit_f   <= 1'b0;
          pw_f    <= 1'b0;
          va_en   <= 1'b0;
          bound_f <= 1'b0;
          status  <= (s_axis_tuser && (in_sin == 10'd0 || {1'b0, in_sin} >= fill)) ?
                     ST_BAD_UNLOCK : ST_OK;
        end
      end
      L_BKT: begin
        cur <= bkt_q;
      end
      L_WALK: begin
        if (match) begin
          s     <= cur;
          hit_f <= 1'b1;
          va_en <= 1'b1;
          a     <= rd_data.after;
          b     <= rd_data.prior;
          if (rd_data.refs == REF_MAX) begin
            status <= ST_OVERFLOW;
          end
        end else begin
          cur <= rd_data.chain;
        end
      end
      M_RD: begin
        a         <= rd_data.after;
        old_frame <= rd_data.frame;
        link_s    <= rd_data.chain;
      end
      R_BKT: begin
        prev <= NO_SLOT;
        cur  <= bkt_q;
      end
      R_WALK: begin
        if (rd_data.chain == s) begin
          prev <= cur;
        end else begin
          cur <= rd_data.chain;
        end
      end
      I_BKT: begin
        pw_f  <= 1'b1;
        va_en <= 1'b1;
      end
      U_RD: begin
        if (rd_data.refs == '0) begin
          status <= ST_BAD_UNLOCK;
        end
      end
      default: begin
      end
    endcase
    if (miss_go) begin
      if (head == NO_SLOT) begin
        status <= ST_NO_FREE;
      end else begin
        s       <= head;
        bound_f <= h_bound;
        if (!h_bound) begin
          a <= head_after;
        end
      end
    end
  end

  // Result word, loaded when the output register is free.
  logic [31:0] va_word, pv_word;
  logic [9:0]  slot_word;

  assign slot_word = va_en ? 10'(s) : 10'd0;
  assign va_word   = va_en ? 32'((32'(base) + 32'(s[SLOT_BITS-1:0])) << PAGE_SHIFT) : 32'd0;
  assign pv_word   = pw_f ? ((32'(page) << PAGE_SHIFT) | 32'd3) : 32'd0;

  always_ff @(posedge clk) begin
    if (state == FIN && out_free) begin
      m_axis_tdata <= {2'b00, req_cnt, hit_cnt, status, pv_word, pw_f, hit_f,
                       va_word, slot_word};
    end
  end

endmodule
